/* design/pam_pkg.sv */
// ----------------------------------------------------------------------------
// pam_pkg - shared types and constants for the pad autorepeat mapper
// Field widths, register map, reset values and the bundles passed between
// the mapper's submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package pam_pkg;

  localparam int NUM_PORTS  = 2;
  localparam int PORT_W     = 1;
  localparam int BTN_W      = 16;
  localparam int DIR_W      = 8;
  localparam int WORD_W     = BTN_W + DIR_W;
  localparam int AXIS_W     = 8;
  localparam int CNT_W      = 8;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;
  localparam int IN_DATA_W  = BTN_W + 4 * AXIS_W;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 2 * WORD_W + AXIS_W;
  localparam int OUT_USER_W = 1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [AXIS_W-1:0] axis_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_HIGH_THR     = 3'd0,
    REG_LOW_THR      = 3'd1,
    REG_RPT_START    = 3'd2,
    REG_SLOW_RELOAD  = 3'd3,
    REG_FAST_RELOAD  = 3'd4,
    REG_SLOW_REPEATS = 3'd5
  } reg_idx_t;

  localparam axis_t RST_HIGH_THR     = 8'd191;
  localparam axis_t RST_LOW_THR      = 8'd64;
  localparam cnt_t  RST_RPT_START    = 8'd21;
  localparam cnt_t  RST_SLOW_RELOAD  = 8'd17;
  localparam cnt_t  RST_FAST_RELOAD  = 8'd19;
  localparam cnt_t  RST_SLOW_REPEATS = 8'd20;

  typedef struct packed {
    axis_t high_thr;
    axis_t low_thr;
    cnt_t  rpt_start;
    cnt_t  slow_reload;
    cnt_t  fast_reload;
    cnt_t  slow_repeats;
  } cfg_regs_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic              pad_ready;
    logic              read_ok;
    logic [BTN_W-1:0]  buttons_raw;
    axis_t             right_horiz;
    axis_t             right_vert;
    axis_t             left_horiz;
    axis_t             left_vert;
  } poll_t;

  typedef struct packed {
    word_t press_word;
    word_t held_word;
    axis_t stick_amount;
    logic  read_done;
  } result_t;

  // per-request control shared by the stick and typematic units
  typedef struct packed {
    logic advance;    // request in the input register moves to the result register
    logic port_ok;    // port index within range
    logic good;       // port ok, ready and read succeeded
  } step_ctl_t;

endpackage

`default_nettype wire

/* design/pam_cfg.sv */
// ----------------------------------------------------------------------------
// pam_cfg - configuration register file
// APB-style write/read access to the thresholds and repeat timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pam_cfg
  import pam_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_regs_t              regs
);

  cfg_regs_t regs_r;
  reg_idx_t  idx;
  logic      wr_en;
  axis_t     rd_val;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign regs   = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.high_thr     <= RST_HIGH_THR;
      regs_r.low_thr      <= RST_LOW_THR;
      regs_r.rpt_start    <= RST_RPT_START;
      regs_r.slow_reload  <= RST_SLOW_RELOAD;
      regs_r.fast_reload  <= RST_FAST_RELOAD;
      regs_r.slow_repeats <= RST_SLOW_REPEATS;
    end else if (wr_en) begin
      case (idx)
        REG_HIGH_THR:     regs_r.high_thr     <= pwdata[AXIS_W-1:0];
        REG_LOW_THR:      regs_r.low_thr      <= pwdata[AXIS_W-1:0];
        REG_RPT_START:    regs_r.rpt_start    <= pwdata[CNT_W-1:0];
        REG_SLOW_RELOAD:  regs_r.slow_reload  <= pwdata[CNT_W-1:0];
        REG_FAST_RELOAD:  regs_r.fast_reload  <= pwdata[CNT_W-1:0];
        REG_SLOW_REPEATS: regs_r.slow_repeats <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HIGH_THR:     rd_val = regs_r.high_thr;
      REG_LOW_THR:      rd_val = regs_r.low_thr;
      REG_RPT_START:    rd_val = regs_r.rpt_start;
      REG_SLOW_RELOAD:  rd_val = regs_r.slow_reload;
      REG_FAST_RELOAD:  rd_val = regs_r.fast_reload;
      REG_SLOW_REPEATS: rd_val = regs_r.slow_repeats;
      default:          rd_val = '0;
    endcase
  end

  assign prdata = {{(CFG_DW-AXIS_W){1'b0}}, rd_val};

endmodule

`default_nettype wire

/* design/pam_stick.sv */
// ----------------------------------------------------------------------------
// pam_stick - stick to direction substitution
// Inverts the buttons and, on every second good read, replaces the word with
// the one-hot direction of the highest-priority deflected axis.
// ----------------------------------------------------------------------------
`default_nettype none

module pam_stick
  import pam_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire step_ctl_t ctl,
  input  wire poll_t     poll,
  input  wire cfg_regs_t regs,
  output word_t          word,
  output axis_t          amount
);

  logic             phase_r;
  axis_t            value_r;
  logic             use_stick;
  logic [DIR_W-1:0] hit;
  logic [DIR_W-1:0] first;
  axis_t            amt [DIR_W];
  axis_t            sel_amt;

  assign use_stick = ~phase_r;

  // priority order: rh+, rh-, rv-, rv+, lh+, lh-, lv-, lv+
  always_comb begin
    hit[0] = poll.right_horiz >= regs.high_thr;
    hit[1] = poll.right_horiz <= regs.low_thr;
    hit[2] = poll.right_vert  <= regs.low_thr;
    hit[3] = poll.right_vert  >= regs.high_thr;
    hit[4] = poll.left_horiz  >= regs.high_thr;
    hit[5] = poll.left_horiz  <= regs.low_thr;
    hit[6] = poll.left_vert   <= regs.low_thr;
    hit[7] = poll.left_vert   >= regs.high_thr;
    amt[0] = poll.right_horiz - regs.high_thr;
    amt[1] = regs.low_thr - poll.right_horiz;
    amt[2] = regs.low_thr - poll.right_vert;
    amt[3] = poll.right_vert - regs.high_thr;
    amt[4] = poll.left_horiz - regs.high_thr;
    amt[5] = regs.low_thr - poll.left_horiz;
    amt[6] = regs.low_thr - poll.left_vert;
    amt[7] = poll.left_vert - regs.high_thr;
  end

  // isolate lowest set bit
  assign first = hit & (~hit + DIR_W'(1));

  always_comb begin
    sel_amt = '0;
    for (int k = 0; k < DIR_W; k++) begin
      if (first[k]) begin
        sel_amt = sel_amt | amt[k];
      end
    end
  end

  always_comb begin
    if (use_stick && (|hit)) begin
      word = {first, {BTN_W{1'b0}}};
    end else begin
      word = {{DIR_W{1'b0}}, ~poll.buttons_raw};
    end
    amount = (ctl.good && use_stick) ? sel_amt : value_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      value_r <= '0;
    end else if (ctl.advance && ctl.good) begin
      phase_r <= ~phase_r;
      if (use_stick) begin
        value_r <= sel_amt;
      end
    end
  end

endmodule

`default_nettype wire

/* design/pam_typematic.sv */
// ----------------------------------------------------------------------------
// pam_typematic - per-port press detection and auto-repeat
// Keeps the previous word, hold and repeat counters and last press of each
// port and forms the press, held and read done outputs for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module pam_typematic
  import pam_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire step_ctl_t ctl,
  input  wire poll_t     poll,
  input  wire word_t     word,
  input  wire cfg_regs_t regs,
  output word_t          press_word,
  output word_t          held_word,
  output logic           read_done
);

  word_t prev_r  [NUM_PORTS];
  cnt_t  hold_r  [NUM_PORTS];
  cnt_t  rpt_r   [NUM_PORTS];
  word_t last_r  [NUM_PORTS];

  word_t prev_q, last_q;
  cnt_t  hold_q, rpt_q, hold_inc;
  word_t prev_nxt, last_nxt;
  cnt_t  hold_nxt, rpt_nxt;
  logic  [PORT_W-1:0] p;

  assign p      = poll.port;
  assign prev_q = prev_r[p];
  assign hold_q = hold_r[p];
  assign rpt_q  = rpt_r[p];
  assign last_q = last_r[p];

  assign hold_inc = (hold_q != {CNT_W{1'b1}}) ? hold_q + CNT_W'(1) : hold_q;

  always_comb begin
    prev_nxt   = prev_q;
    hold_nxt   = hold_q;
    rpt_nxt    = rpt_q;
    last_nxt   = last_q;
    press_word = '0;
    held_word  = '0;
    read_done  = 1'b0;
    if (ctl.port_ok) begin
      held_word = prev_q;
      if (!poll.pad_ready) begin
        last_nxt = '0;
      end else if (!poll.read_ok) begin
        press_word = last_q;
      end else begin
        held_word  = word;
        read_done  = 1'b1;
        press_word = word & ~prev_q;
        if (prev_q == word) begin
          hold_nxt = hold_inc;
          if (hold_inc >= regs.rpt_start) begin
            press_word = word;
            hold_nxt   = (rpt_q < regs.slow_repeats) ? regs.slow_reload : regs.fast_reload;
            rpt_nxt    = (rpt_q != {CNT_W{1'b1}}) ? rpt_q + CNT_W'(1) : rpt_q;
          end
        end else begin
          hold_nxt = '0;
          rpt_nxt  = '0;
          prev_nxt = word;
        end
        last_nxt = press_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PORTS; k++) begin
        prev_r[k] <= '0;
        hold_r[k] <= '0;
        rpt_r[k]  <= '0;
        last_r[k] <= '0;
      end
    end else if (ctl.advance && ctl.port_ok) begin
      prev_r[p] <= prev_nxt;
      hold_r[p] <= hold_nxt;
      rpt_r[p]  <= rpt_nxt;
      last_r[p] <= last_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/pad_autorepeat_joystick_mapper.sv */
// ----------------------------------------------------------------------------
// pad_autorepeat_joystick_mapper - controller poll mapper with auto-repeat
// Turns controller polls into held and press words with stick directions.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   one poll request per transfer: port, ready and read status in
//          tuser, buttons and four stick axes in tdata.
//   out_*  one result per poll: press word, held word, stick amount in tdata,
//          read done flag in tuser.
//   cfg_*  APB-style register port, thresholds and repeat timing; write only
//          while no request is in flight.
// A request is registered on acceptance, processed by one level of compare
// and counter logic and lands in the result register, which drives out_tvalid.
// One request per cycle is sustained while the receiver does not stall; the
// per-port state is read and written as the request moves on, so consecutive
// polls of the same port chain directly.
// When the receiver stalls the result register holds and the input register
// fills; in_tready drops only when both are occupied.
// Reset clears all per-port state, the stick phase and amount, and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module pad_autorepeat_joystick_mapper
  import pam_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // tdata: buttons_raw, right_horiz, right_vert, left_horiz, left_vert
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: port, pad_ready, read_ok
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // tdata: press_word, held_word, stick_amount
  output logic      [OUT_DATA_W-1:0] out_tdata,
  // tuser: read_done
  output logic      [OUT_USER_W-1:0] out_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_AW-1:0]     cfg_paddr,
  input  wire logic [CFG_DW-1:0]     cfg_pwdata,
  output logic      [CFG_DW-1:0]     cfg_prdata,
  output logic                       cfg_pready
);

  cfg_regs_t regs;
  step_ctl_t ctl;
  poll_t     in_poll_r, in_poll_nxt;
  logic      in_v_r, in_v_nxt;
  result_t   out_res_r, out_res_nxt;
  logic      out_v_r, out_v_nxt;
  logic      accept;
  word_t     word;
  word_t     press_word, held_word;
  axis_t     stick_amount;
  logic      read_done;

  pam_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (regs)
  );

  always_comb begin
    ctl.advance = in_v_r & (~out_v_r | out_tready);
    ctl.port_ok = (int'(in_poll_r.port) < NUM_PORTS);
    ctl.good    = ctl.port_ok & in_poll_r.pad_ready & in_poll_r.read_ok;
  end

  assign in_tready = ~in_v_r | ctl.advance;
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    in_poll_nxt.port        = in_tuser[0 +: PORT_W];
    in_poll_nxt.pad_ready   = in_tuser[PORT_W];
    in_poll_nxt.read_ok     = in_tuser[PORT_W+1];
    in_poll_nxt.buttons_raw = in_tdata[BTN_W-1:0];
    in_poll_nxt.right_horiz = in_tdata[BTN_W +: AXIS_W];
    in_poll_nxt.right_vert  = in_tdata[BTN_W+AXIS_W +: AXIS_W];
    in_poll_nxt.left_horiz  = in_tdata[BTN_W+2*AXIS_W +: AXIS_W];
    in_poll_nxt.left_vert   = in_tdata[BTN_W+3*AXIS_W +: AXIS_W];
    in_v_nxt = accept ? 1'b1 : (ctl.advance ? 1'b0 : in_v_r);
  end

  pam_stick u_stick (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .poll   (in_poll_r),
    .regs   (regs),
    .word   (word),
    .amount (stick_amount)
  );

  pam_typematic u_typematic (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .poll       (in_poll_r),
    .word       (word),
    .regs       (regs),
    .press_word (press_word),
    .held_word  (held_word),
    .read_done  (read_done)
  );

  always_comb begin
    out_res_nxt.press_word   = press_word;
    out_res_nxt.held_word    = held_word;
    // out-of-range port gives all zeros
    out_res_nxt.stick_amount = ctl.port_ok ? stick_amount : '0;
    out_res_nxt.read_done    = read_done;
    out_v_nxt = ctl.advance ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_poll_r <= in_poll_nxt;
    end
    if (ctl.advance) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_res_r.stick_amount, out_res_r.held_word, out_res_r.press_word};
  assign out_tuser  = out_res_r.read_done;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - testbench for pad_autorepeat_joystick_mapper
// Streams controller poll requests with random gaps and output stalls,
// predicts held word, press word, stick amount and read status for every
// request, and compares each result in order. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_top;
  import pam_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 7;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 325;
  localparam int N_DIR        = 24;
  localparam cnt_t CNT_MAX    = '1;
  localparam axis_t MID       = 8'd128;
  // per direction bit: 1 when the positive side of its axis is tested
  localparam logic [DIR_W-1:0] DIR_POSITIVE = 8'b1001_1001;

  typedef struct packed {
    poll_t   p;
    logic    typed;
    result_t want;
  } dir_row_t;

  // port, ready, ok, raw, rh, rv, lh, lv | typed, press, held, amount, done
  localparam dir_row_t DIR_TBL [N_DIR] = '{
    '{'{1'b0, 1'b0, 1'b0, 16'hFFFF, MID, MID, MID, MID}, 1'b1, '{24'h0, 24'h0, 8'd0, 1'b0}},
    '{'{1'b1, 1'b1, 1'b0, 16'hFFFF, MID, MID, MID, MID}, 1'b1, '{24'h0, 24'h0, 8'd0, 1'b0}},
    '{'{1'b0, 1'b1, 1'b1, 16'hFFFF, MID, MID, MID, MID}, 1'b1, '{24'h0, 24'h0, 8'd0, 1'b1}},
    '{'{1'b0, 1'b1, 1'b1, 16'h0000, MID, MID, MID, MID}, 1'b1,
      '{24'h00FFFF, 24'h00FFFF, 8'd0, 1'b1}},
    // read failure repeats the last press, not ready clears it
    '{'{1'b0, 1'b1, 1'b0, 16'h0000, MID, MID, MID, MID}, 1'b1,
      '{24'h00FFFF, 24'h00FFFF, 8'd0, 1'b0}},
    '{'{1'b0, 1'b0, 1'b1, 16'h0000, MID, MID, MID, MID}, 1'b1,
      '{24'h0, 24'h00FFFF, 8'd0, 1'b0}},
    '{'{1'b0, 1'b1, 1'b0, 16'h0000, MID, MID, MID, MID}, 1'b1,
      '{24'h0, 24'h00FFFF, 8'd0, 1'b0}},
    '{'{1'b1, 1'b1, 1'b1, 16'hFFFE, 8'hFF, MID, MID, MID}, 1'b1,
      '{24'h010000, 24'h010000, 8'd64, 1'b1}},
    // stick turns alternate: even rows below are off turns
    '{'{1'b1, 1'b1, 1'b1, 16'h1234, 8'h00, MID, MID, MID}, 1'b0, '0},
    '{'{1'b0, 1'b1, 1'b1, 16'hAAAA, 8'h00, MID, MID, MID}, 1'b0, '0},
    '{'{1'b1, 1'b1, 1'b1, 16'h5555, MID, MID, MID, MID}, 1'b0, '0},
    '{'{1'b0, 1'b1, 1'b1, 16'h0F0F, MID, 8'h00, MID, MID}, 1'b0, '0},
    '{'{1'b1, 1'b1, 1'b1, 16'h5555, MID, MID, MID, MID}, 1'b0, '0},
    '{'{1'b0, 1'b1, 1'b1, 16'hF0F0, MID, 8'hFF, MID, MID}, 1'b0, '0},
    '{'{1'b1, 1'b1, 1'b1, 16'h5555, MID, MID, MID, MID}, 1'b0, '0},
    '{'{1'b0, 1'b1, 1'b1, 16'h8001, MID, MID, 8'hFF, MID}, 1'b0, '0},
    '{'{1'b1, 1'b1, 1'b1, 16'h7FFE, MID, MID, MID, MID}, 1'b0, '0},
    '{'{1'b0, 1'b1, 1'b1, 16'h0001, MID, MID, 8'h00, MID}, 1'b0, '0},
    '{'{1'b1, 1'b1, 1'b1, 16'h7FFE, MID, MID, MID, MID}, 1'b0, '0},
    '{'{1'b0, 1'b1, 1'b1, 16'hFF00, MID, MID, MID, 8'h00}, 1'b0, '0},
    '{'{1'b1, 1'b1, 1'b1, 16'h00FF, MID, MID, MID, MID}, 1'b0, '0},
    '{'{1'b0, 1'b1, 1'b1, 16'hC3C3, MID, MID, MID, 8'hBF}, 1'b0, '0},
    '{'{1'b1, 1'b1, 1'b1, 16'h3C3C, 8'hFF, 8'h00, 8'hFF, 8'h00}, 1'b0, '0},
    // several axes past threshold at once, priority picks right vertical
    '{'{1'b0, 1'b1, 1'b1, 16'h9999, MID, 8'h40, 8'hFF, 8'h00}, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  // predictor state
  cfg_regs_t mdl_cfg;
  word_t     held_prev [NUM_PORTS];
  cnt_t      hold_cnt [NUM_PORTS];
  cnt_t      rpt_cnt [NUM_PORTS];
  word_t     press_last [NUM_PORTS];
  logic      stick_turn;
  axis_t     stick_amt;

  result_t   results_due [$];
  int        err_count = 0;
  bit        no_idle = 1'b0;
  int        idle_cycles = 0;
  int        stall_left = 0;
  int        rx_gap;

  pad_autorepeat_joystick_mapper uut (.*);

  always #HALF_PERIOD clk = ~clk;

  function automatic result_t predict_poll(poll_t p);
    result_t r;
    word_t   word;
    word_t   press;
    axis_t   axv [DIR_W];
    axis_t   amt;
    bit      hit;
    int      i;
    r = '0;
    i = int'(p.port);
    if (i >= NUM_PORTS) return r;
    if (!p.pad_ready || !p.read_ok) begin
      if (!p.pad_ready) press_last[i] = '0;
      r.press_word   = press_last[i];
      r.held_word    = held_prev[i];
      r.stick_amount = stick_amt;
      return r;
    end
    word = {{DIR_W{1'b0}}, ~p.buttons_raw};
    stick_turn = ~stick_turn;
    if (stick_turn) begin
      axv = '{p.right_horiz, p.right_horiz, p.right_vert, p.right_vert,
              p.left_horiz, p.left_horiz, p.left_vert, p.left_vert};
      amt = '0;
      hit = 1'b0;
      for (int k = 0; k < DIR_W; k++) begin
        if (!hit && DIR_POSITIVE[k] && axv[k] >= mdl_cfg.high_thr) begin
          hit = 1'b1;
          amt = axv[k] - mdl_cfg.high_thr;
        end else if (!hit && !DIR_POSITIVE[k] && axv[k] <= mdl_cfg.low_thr) begin
          hit = 1'b1;
          amt = mdl_cfg.low_thr - axv[k];
        end
        if (hit) begin
          word = '0;
          word[BTN_W + k] = 1'b1;
          break;
        end
      end
      stick_amt = amt;
    end
    press = word & ~held_prev[i];
    if (held_prev[i] == word) begin
      if (hold_cnt[i] != CNT_MAX) hold_cnt[i]++;
      if (hold_cnt[i] >= mdl_cfg.rpt_start) begin
        press = word;
        hold_cnt[i] = (rpt_cnt[i] < mdl_cfg.slow_repeats) ? mdl_cfg.slow_reload
                                                          : mdl_cfg.fast_reload;
        if (rpt_cnt[i] != CNT_MAX) rpt_cnt[i]++;
      end
    end else begin
      hold_cnt[i]  = '0;
      rpt_cnt[i]   = '0;
      held_prev[i] = word;
    end
    press_last[i]  = press;
    r.press_word   = press;
    r.held_word    = word;
    r.stick_amount = stick_amt;
    r.read_done    = 1'b1;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic axis_t pick_center();
    int lo;
    int hi;
    lo = int'(mdl_cfg.low_thr) + 1;
    hi = int'(mdl_cfg.high_thr) - 1;
    if (lo > hi) return axis_t'($urandom);
    return axis_t'($urandom_range(lo, hi));
  endfunction

  function automatic axis_t pick_axis();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return mdl_cfg.high_thr;
      3: return mdl_cfg.high_thr - 8'd1;
      4: return mdl_cfg.low_thr;
      5: return mdl_cfg.low_thr + 8'd1;
      6, 7: return pick_center();
      default: return axis_t'($urandom);
    endcase
  endfunction

  task automatic send_poll(input poll_t p, input logic typed, input result_t want);
    result_t due;
    int      gap;
    in_tdata  <= {p.left_vert, p.left_horiz, p.right_vert, p.right_horiz, p.buttons_raw};
    in_tuser  <= {p.read_ok, p.pad_ready, p.port};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    due = predict_poll(p);
    results_due.push_back(typed ? want : due);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // back-to-back writes keep psel high, the caller releases the bus
  task automatic write_reg(input reg_idx_t idx, input axis_t val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {{(CFG_DW - AXIS_W){1'b0}}, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_HIGH_THR:     mdl_cfg.high_thr     = val;
      REG_LOW_THR:      mdl_cfg.low_thr      = val;
      REG_RPT_START:    mdl_cfg.rpt_start    = val;
      REG_SLOW_RELOAD:  mdl_cfg.slow_reload  = val;
      REG_FAST_RELOAD:  mdl_cfg.fast_reload  = val;
      REG_SLOW_REPEATS: mdl_cfg.slow_repeats = val;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input axis_t hi_thr, input axis_t lo_thr, input cnt_t start,
                           input cnt_t slow, input cnt_t fast, input cnt_t reps);
    write_reg(REG_HIGH_THR, hi_thr);
    write_reg(REG_LOW_THR, lo_thr);
    write_reg(REG_RPT_START, start);
    write_reg(REG_SLOW_RELOAD, slow);
    write_reg(REG_FAST_RELOAD, fast);
    write_reg(REG_SLOW_REPEATS, reps);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      rx_gap = pick_gap();
      out_tready <= (rx_gap == 0);
      stall_left <= (rx_gap > 0) ? rx_gap - 1 : 0;
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.press_word   = out_tdata[WORD_W-1:0];
      got.held_word    = out_tdata[2*WORD_W-1:WORD_W];
      got.stick_amount = out_tdata[OUT_DATA_W-1:2*WORD_W];
      got.read_done    = out_tuser[0];
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result tdata %h tuser %h", $time, out_tdata, out_tuser);
        err_count++;
      end else begin
        want = results_due.pop_front();
        if (got.press_word !== want.press_word)
          $display("%0t: press_word expected %06h got %06h", $time,
                   want.press_word, got.press_word);
        if (got.held_word !== want.held_word)
          $display("%0t: held_word expected %06h got %06h", $time,
                   want.held_word, got.held_word);
        if (got.stick_amount !== want.stick_amount)
          $display("%0t: stick_amount expected %02h got %02h", $time,
                   want.stick_amount, got.stick_amount);
        if (got.read_done !== want.read_done)
          $display("%0t: read_done expected %0d got %0d", $time,
                   want.read_done, got.read_done);
        if (got !== want) err_count++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    poll_t        p;
    logic [0:0]   run_port;
    logic [15:0]  run_raw;
    int           sent;
    int           kind;
    int           len;
    mdl_cfg = '{RST_HIGH_THR, RST_LOW_THR, RST_RPT_START, RST_SLOW_RELOAD,
                RST_FAST_RELOAD, RST_SLOW_REPEATS};
    for (int i = 0; i < NUM_PORTS; i++) begin
      held_prev[i]  = '0;
      hold_cnt[i]   = '0;
      rpt_cnt[i]    = '0;
      press_last[i] = '0;
    end
    stick_turn = 1'b0;
    stick_amt  = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) send_poll(DIR_TBL[r].p, DIR_TBL[r].typed, DIR_TBL[r].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          // every poll of a held word repeats, repeat count saturates
          1: apply_cfg(8'hFF, 8'h00, 8'd1, 8'd0, 8'd0, 8'hFF);
          // reloads at the top, hold count saturates
          2: apply_cfg(8'd200, 8'd50, 8'hFF, 8'hFF, 8'hFF, 8'd0);
          // crossed thresholds
          3: apply_cfg(8'd100, 8'd150, cnt_t'($urandom_range(1, 40)), cnt_t'($urandom),
                       cnt_t'($urandom), cnt_t'($urandom));
          4: apply_cfg(8'd0, 8'hFF, cnt_t'($urandom_range(1, 40)), cnt_t'($urandom),
                       cnt_t'($urandom), cnt_t'($urandom));
          default: apply_cfg(axis_t'($urandom_range(150, 255)),
                             axis_t'($urandom_range(0, 100)),
                             cnt_t'($urandom_range(1, 30)), cnt_t'($urandom_range(0, 30)),
                             cnt_t'($urandom_range(0, 30)), cnt_t'($urandom_range(0, 30)));
        endcase
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        no_idle = ($urandom_range(0, 5) == 0);
        kind = $urandom_range(0, 9);
        if (sent == 0 && (ph == 1 || ph == 2)) kind = 0;
        if (kind < 5) begin
          // held buttons with centered sticks, some noise mixed in
          if (sent == 0 && (ph == 1 || ph == 2)) len = $urandom_range(270, 300);
          else len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 280)
                                                  : $urandom_range(1, 40);
          run_port = 1'($urandom_range(0, 1));
          run_raw  = 16'($urandom);
          if ($urandom_range(0, 7) == 0) run_raw = '1;
          for (int n = 0; n < len; n++) begin
            p.port        = run_port;
            p.pad_ready   = 1'b1;
            p.read_ok     = 1'b1;
            p.buttons_raw = run_raw;
            p.right_horiz = pick_center();
            p.right_vert  = pick_center();
            p.left_horiz  = pick_center();
            p.left_vert   = pick_center();
            if ($urandom_range(0, 11) == 0) begin
              p.port        = 1'($urandom_range(0, 1));
              p.pad_ready   = 1'($urandom_range(0, 1));
              p.read_ok     = 1'($urandom_range(0, 1));
              p.buttons_raw = 16'($urandom);
            end
            send_poll(p, 1'b0, '0);
            sent++;
          end
        end else if (kind < 7) begin
          // stick play on one port
          len = $urandom_range(2, 12);
          run_port = 1'($urandom_range(0, 1));
          run_raw  = 16'($urandom);
          for (int n = 0; n < len; n++) begin
            p.port        = run_port;
            p.pad_ready   = ($urandom_range(0, 9) != 0);
            p.read_ok     = ($urandom_range(0, 9) != 0);
            p.buttons_raw = run_raw;
            p.right_horiz = pick_axis();
            p.right_vert  = pick_axis();
            p.left_horiz  = pick_axis();
            p.left_vert   = pick_axis();
            send_poll(p, 1'b0, '0);
            sent++;
          end
        end else begin
          p = poll_t'({$urandom, $urandom});
          send_poll(p, 1'b0, '0);
          sent++;
          if ($urandom_range(0, 39) == 0) wait_drained();
        end
      end
    end

    wait_drained();
    if (err_count == 0 && results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
